// File: rtl/escape_sequence_decoder_core_defines.svh
// Assertion macros shared by the escape sequence decoder RTL.
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define ESD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ESD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/esd_pkg.sv
// Types and constants of the escape sequence decoder.
package esd_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W  = 13;
  localparam int ACC_W  = 9;

  localparam int ESD_MAX_CHARS = 4096;
  localparam logic [LEN_W-1:0] MAX_OUT_LEN_RESET = 13'd4096;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_LIMIT = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_NONE = 3'b001,
    MODE_OCT  = 3'b010,
    MODE_HEX  = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [1:0]         digits_needed;
    logic [1:0]         digits_seen;
    logic [ACC_W-1:0]   value_accum;
    logic [LEN_W-1:0]   out_count;
    logic               halted;
  } esd_state_t;

  localparam esd_state_t STATE_CLEAR = '{
    mode:          MODE_NONE,
    digits_needed: 2'd0,
    digits_seen:   2'd0,
    value_accum:   '0,
    out_count:     '0,
    halted:        1'b0
  };

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  out_byte;
    logic [LEN_W-1:0]   out_length;
    logic [LEN_W-1:0]   error_pos;
  } esd_result_t;

endpackage

// File: rtl/esd_if.sv
// Channel interfaces of the escape sequence decoder: characters, results, config.
interface esd_char_if import esd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              end_of_string;

  modport source (output valid, in_char, end_of_string, input ready);
  modport sink (input valid, in_char, end_of_string, output ready);
endinterface

interface esd_result_if import esd_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [CHAR_W-1:0] out_byte;
  logic [LEN_W-1:0] out_length;
  logic [LEN_W-1:0] error_pos;

  modport source (output valid, kind, out_byte, out_length, error_pos, input ready);
  modport sink (input valid, kind, out_byte, out_length, error_pos, output ready);
endinterface

interface esd_cfg_if import esd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/esd_step.sv
// Next-state and result logic for one character or end-of-string item.
module esd_step import esd_pkg::*; #(
  parameter int MAX_CHARS = ESD_MAX_CHARS,
  localparam int POS_W = $clog2(MAX_CHARS + 1)
) (
  input  esd_state_t        st,
  input  logic [POS_W-1:0]  char_pos,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              end_of_string,
  input  logic [LEN_W-1:0]  max_out_len,
  output esd_state_t        st_next,
  output logic [POS_W-1:0]  char_pos_next,
  output logic              res_valid,
  output esd_result_t       res
);

  localparam logic [CHAR_W-1:0] CH_BSL = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_X   = 8'h78;
  localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_7   = 8'h37;
  localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h66;

  logic [POS_W-1:0]  pos_inc;
  logic              oct_ok;
  logic              hex_ok;
  logic [3:0]        hex_val;
  logic              digit_ok;
  logic [ACC_W-1:0]  acc_new;
  logic [1:0]        seen_new;
  logic              emit;
  logic [CHAR_W-1:0] emit_byte;
  logic [LEN_W-1:0]  count_new;

  assign pos_inc = (char_pos < POS_W'(MAX_CHARS)) ? char_pos + POS_W'(1) : char_pos;

  // digit classification
  always_comb begin
    oct_ok  = (in_char >= CH_0) && (in_char <= CH_7);
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    priority if ((in_char >= CH_0) && (in_char <= CH_9)) begin
      hex_val = in_char[3:0];
    end else if ((in_char >= CH_UA) && (in_char <= CH_UF)) begin
      hex_val = 4'(in_char - CH_UA + 8'd10);
    end else if ((in_char >= CH_LA) && (in_char <= CH_LF)) begin
      hex_val = 4'(in_char - CH_LA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign digit_ok = (st.mode == MODE_HEX) ? hex_ok : oct_ok;
  assign acc_new  = (st.mode == MODE_HEX) ? {st.value_accum[4:0], hex_val}
                                          : {st.value_accum[5:0], in_char[2:0]};
  assign seen_new = st.digits_seen + 2'd1;
  assign count_new = st.out_count + LEN_W'(1);

  always_comb begin
    st_next       = st;
    char_pos_next = char_pos;
    res_valid     = 1'b0;
    res           = '{kind: KIND_DATA, default: '0};
    emit          = 1'b0;
    emit_byte     = '0;

    if (end_of_string) begin
      if (!st.halted) begin
        res_valid = 1'b1;
        if (st.mode != MODE_NONE) begin
          res.kind      = KIND_ERROR;
          res.error_pos = LEN_W'(char_pos);
        end else begin
          res.kind       = KIND_DONE;
          res.out_length = st.out_count;
        end
      end
      st_next       = STATE_CLEAR;
      char_pos_next = '0;
    end else if (!st.halted) begin
      char_pos_next = pos_inc;
      unique case (st.mode)
        MODE_NONE: begin
          if (in_char == CH_BSL) begin
            st_next.mode          = MODE_OCT;
            st_next.digits_needed = 2'd3;
            st_next.digits_seen   = 2'd0;
            st_next.value_accum   = '0;
          end else begin
            emit      = 1'b1;
            emit_byte = in_char;
          end
        end
        MODE_OCT, MODE_HEX: begin
          priority if (in_char == CH_X) begin
            if (st.digits_seen != 2'd0) begin
              st_next.halted = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_pos  = LEN_W'(pos_inc);
            end else begin
              st_next.mode          = MODE_HEX;
              st_next.digits_needed = 2'd2;
            end
          end else if (in_char == CH_BSL) begin
            emit      = 1'b1;
            emit_byte = CH_BSL;
          end else if (!digit_ok) begin
            st_next.halted = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_pos  = LEN_W'(pos_inc);
          end else begin
            st_next.value_accum = acc_new;
            st_next.digits_seen = seen_new;
            if (seen_new == st.digits_needed) begin
              emit      = 1'b1;
              emit_byte = acc_new[CHAR_W-1:0];
            end
          end
        end
        default: begin
          st_next.mode = MODE_NONE;
        end
      endcase

      if (emit) begin
        st_next.mode      = MODE_NONE;
        st_next.out_count = count_new;
        res_valid         = 1'b1;
        res.out_byte      = emit_byte;
        if (count_new >= max_out_len) begin
          st_next.halted = 1'b1;
          res.kind       = KIND_LIMIT;
          res.out_length = count_new;
        end else begin
          res.kind = KIND_DATA;
        end
      end
    end
  end

endmodule

// File: rtl/escape_sequence_decoder_core.sv
// Top level of the escape sequence decoder.
// Takes one character (or end-of-string marker) per cycle while src.ready is
// high and gives at most one result per item: a decoded byte, a byte that hits
// the output limit, a string done report, or an error with its position.
// Throughput is one item per clock unless src.ready drops. A result reaches dst
// via the input and result registers on either side of the single decode step.
// The result register holds a result while dst stalls; items still enter until
// the input register holds one with a result, then src.ready drops until dst
// drains. cfg is always ready; write max_out_len only while the block is idle.
`include "escape_sequence_decoder_core_defines.svh"

module escape_sequence_decoder_core import esd_pkg::*; #(
  parameter int MAX_CHARS = ESD_MAX_CHARS
) (
  input  logic           clk,
  input  logic           rst,
  esd_char_if.sink       src,
  esd_result_if.source   dst,
  esd_cfg_if.sink        cfg
);

  localparam int POS_W = $clog2(MAX_CHARS + 1);

  logic [LEN_W-1:0]  max_out_len;

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_eos;

  esd_state_t        st;
  esd_state_t        st_next;
  logic [POS_W-1:0]  char_pos;
  logic [POS_W-1:0]  char_pos_next;

  logic              res_valid;
  esd_result_t       res;
  logic              out_valid;
  esd_result_t       out_res;

  logic              s1_adv;

  esd_step #(
    .MAX_CHARS (MAX_CHARS)
  ) u_step (
    .st            (st),
    .char_pos      (char_pos),
    .in_char       (s1_char),
    .end_of_string (s1_eos),
    .max_out_len   (max_out_len),
    .st_next       (st_next),
    .char_pos_next (char_pos_next),
    .res_valid     (res_valid),
    .res           (res)
  );

  // an item with no result never waits on the output register
  assign s1_adv    = s1_valid && (!res_valid || !out_valid || dst.ready);
  assign src.ready = !s1_valid || s1_adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= MAX_OUT_LEN_RESET;
    end else if (cfg.valid) begin
      max_out_len <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src.ready) begin
      s1_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.ready && src.valid) begin
      s1_char <= src.in_char;
      s1_eos  <= src.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= STATE_CLEAR;
      char_pos <= '0;
    end else if (s1_adv) begin
      st       <= st_next;
      char_pos <= char_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res <= res;
    end
  end

  assign dst.valid      = out_valid;
  assign dst.kind       = out_res.kind;
  assign dst.out_byte   = out_res.out_byte;
  assign dst.out_length = out_res.out_length;
  assign dst.error_pos  = out_res.error_pos;

  `ESD_ASSERT_ALWAYS(a_pos_saturates, char_pos <= POS_W'(MAX_CHARS), "char_pos past limit")
  `ESD_ASSERT_SAME(a_stall_cause, !src.ready, s1_valid && out_valid && !dst.ready, "src stalled without a full output")
  `ESD_ASSERT_NEXT(a_halt_on_stop, s1_adv && res_valid && !s1_eos && (res.kind == KIND_ERROR || res.kind == KIND_LIMIT), st.halted, "no halt after error or limit")
  `ESD_ASSERT_NEXT(a_eos_clears, s1_adv && s1_eos, (char_pos == '0) && (st.out_count == '0) && !st.halted, "string state not cleared")

endmodule

// File: verif/esd_decode_checker.sv
// Decode checker: watches the char, result and config channels, predicts and compares.
module esd_decode_checker import esd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  esd_char_if   src,
  esd_result_if dst,
  esd_cfg_if    cfg,
  output int    mismatches,
  output int    results_owed,
  output int    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CHAR_W-1:0] BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] LETTER_X  = 8'h78;

  // Shadow of the decoder state
  logic [LEN_W-1:0] limit;
  mode_t            esc_mode;
  logic [1:0]       need;
  logic [1:0]       seen;
  logic [ACC_W-1:0] accum;
  logic [LEN_W-1:0] produced;
  logic [LEN_W-1:0] position;
  logic             halted;

  esd_result_t pending_results[$];

  function automatic void clear_string();
    esc_mode = MODE_NONE;
    need     = '0;
    seen     = '0;
    accum    = '0;
    produced = '0;
    position = '0;
    halted   = 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 30) $display("[%0t] decode mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Advances the shadow state by one item; returns 1 when the item yields a result.
  function automatic bit decode_char(input logic [CHAR_W-1:0] c, input logic eos,
                                     output esd_result_t r);
    bit               has;
    bit               ok;
    bit               emit;
    int               base;
    logic [4:0]       d;
    logic [CHAR_W-1:0] b;
    r    = '0;
    ok   = 1'b0;
    emit = 1'b0;
    base = 8;
    d    = '0;
    b    = '0;
    if (eos) begin
      has = !halted;
      if (esc_mode != MODE_NONE) begin
        r.kind      = KIND_ERROR;
        r.error_pos = position;
      end else begin
        r.kind       = KIND_DONE;
        r.out_length = produced;
      end
      clear_string();
      return has;
    end
    if (halted) return 1'b0;
    if (position < ESD_MAX_CHARS) position++;

    if (esc_mode == MODE_NONE) begin
      if (c == BACKSLASH) begin
        esc_mode = MODE_OCT;
        need     = 2'd3;
        seen     = '0;
        accum    = '0;
      end else begin
        emit = 1'b1;
        b    = c;
      end
    end else if (c == LETTER_X) begin
      if (seen != 0) begin
        halted      = 1'b1;
        r.kind      = KIND_ERROR;
        r.error_pos = position;
        return 1'b1;
      end
      esc_mode = MODE_HEX;
      need     = 2'd2;
    end else if (c == BACKSLASH) begin
      // backslash inside an open escape drops the digits and gives a backslash
      emit = 1'b1;
      b    = BACKSLASH;
    end else begin
      if (esc_mode == MODE_HEX) begin
        base = 16;
        if (c >= "0" && c <= "9") begin
          d  = 5'(c - "0");
          ok = 1'b1;
        end else if (c >= "A" && c <= "F") begin
          d  = 5'(c - "A" + 8'd10);
          ok = 1'b1;
        end else if (c >= "a" && c <= "f") begin
          d  = 5'(c - "a" + 8'd10);
          ok = 1'b1;
        end
      end else begin
        ok = (c >= "0" && c <= "7");
        if (ok) d = 5'(c - "0");
      end
      if (!ok) begin
        halted      = 1'b1;
        r.kind      = KIND_ERROR;
        r.error_pos = position;
        return 1'b1;
      end
      accum = ACC_W'(accum * base + d);
      seen  = seen + 2'd1;
      if (seen == need) begin
        emit = 1'b1;
        b    = accum[CHAR_W-1:0];
      end
    end

    if (!emit) return 1'b0;
    esc_mode   = MODE_NONE;
    produced++;
    r.out_byte = b;
    if (produced >= limit) begin
      halted       = 1'b1;
      r.kind       = KIND_LIMIT;
      r.out_length = produced;
    end else begin
      r.kind = KIND_DATA;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    esd_result_t owed;
    esd_result_t predicted;
    if (rst) begin
      limit = MAX_OUT_LEN_RESET;
      clear_string();
      pending_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) limit = cfg.data;

      if (dst.valid && dst.ready) begin
        checked++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %s/%02h/%0d/%0d with nothing expected",
                                    dst.kind.name(), dst.out_byte, dst.out_length,
                                    dst.error_pos));
        end else begin
          owed = pending_results.pop_front();
          if (dst.kind !== owed.kind)
            report_mismatch($sformatf("kind %s, expected %s",
                                      dst.kind.name(), owed.kind.name()));
          if (dst.out_byte !== owed.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      dst.out_byte, owed.out_byte));
          if (dst.out_length !== owed.out_length)
            report_mismatch($sformatf("out_length %0d, expected %0d",
                                      dst.out_length, owed.out_length));
          if (dst.error_pos !== owed.error_pos)
            report_mismatch($sformatf("error_pos %0d, expected %0d",
                                      dst.error_pos, owed.error_pos));
        end
      end

      if (src.valid && src.ready) begin
        if (decode_char(src.in_char, src.end_of_string, predicted))
          pending_results.push_back(predicted);
      end
    end
    results_owed <= pending_results.size();
  end

endmodule

// File: verif/tb_escape_sequence_decoder_core.sv
// Testbench top: clock, reset, character stimulus, config writes and the verdict.
module tb_escape_sequence_decoder_core;
  import esd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CHAR_W-1:0] BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] LETTER_X  = 8'h78;
  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200_000;

  logic clk = 1'b0;
  logic rst;
  bit   calm;
  int   items_sent;
  int   cfg_writes;
  int   cycles;
  int   random_start;
  int   mismatches;
  int   results_owed;
  int   checked;

  esd_char_if   src_ch ();
  esd_result_if dst_ch ();
  esd_cfg_if    cfg_ch ();

  escape_sequence_decoder_core dut (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .dst (dst_ch),
    .cfg (cfg_ch)
  );

  esd_decode_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .src          (src_ch),
    .dst          (dst_ch),
    .cfg          (cfg_ch),
    .mismatches   (mismatches),
    .results_owed (results_owed),
    .checked      (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, results_owed);
      $display("escape_sequence_decoder_core regression: fail");
      $finish;
    end
  end

  // Result sink with a random stall per transaction
  initial begin
    int stall;
    dst_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        dst_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dst_ch.ready <= 1'b1;
      do @(posedge clk); while (!dst_ch.valid);
    end
  end

  task automatic send_item(input logic [CHAR_W-1:0] c, input logic eos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_ch.valid         <= 1'b1;
    src_ch.in_char       <= c;
    src_ch.end_of_string <= eos;
    do @(posedge clk); while (!src_ch.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic end_string();
    send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Wait until every owed result is back, plus a wait longer than the pipeline depth for silent items
  task automatic drain();
    src_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [CHAR_W-1:0] oct_digit();
    return 8'h30 + CHAR_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [CHAR_W-1:0] hex_digit();
    string digits;
    digits = $urandom_range(0, 1) ? "0123456789ABCDEF" : "0123456789abcdef";
    return digits[$urandom_range(0, 15)];
  endfunction

  // Any character that is neither a digit of the mode, an x nor a backslash
  function automatic logic [CHAR_W-1:0] bad_digit(input bit hex);
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (c == BACKSLASH || c == LETTER_X || (c >= "0" && c <= "7") ||
           (hex && ((c >= "8" && c <= "9") || (c >= "A" && c <= "F") ||
                    (c >= "a" && c <= "f"))));
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 13'd1;
      2:       return '1;
      3:       return MAX_OUT_LEN_RESET;
      default: return LEN_W'($urandom_range(2, 30));
    endcase
  endfunction

  // Mostly well-formed escapes with random content, some broken ones
  task automatic random_string();
    int ntok;
    int pick;
    logic [CHAR_W-1:0] c;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        c = CHAR_W'($urandom_range(0, 255));
        if (c == BACKSLASH) c = "A";
        send_item(c, 1'b0);
      end else if (pick < 55) begin
        send_item(BACKSLASH, 1'b0);
        repeat (3) send_item(oct_digit(), 1'b0);
      end else if (pick < 72) begin
        send_item(BACKSLASH, 1'b0);
        send_item(LETTER_X, 1'b0);
        if ($urandom_range(0, 9) == 0) send_item(LETTER_X, 1'b0);
        repeat (2) send_item(hex_digit(), 1'b0);
      end else if (pick < 80) begin
        send_item(BACKSLASH, 1'b0);
        send_item(BACKSLASH, 1'b0);
      end else if (pick < 86) begin
        // open escape cut by a second backslash
        send_item(BACKSLASH, 1'b0);
        if ($urandom_range(0, 1)) send_item(LETTER_X, 1'b0);
        repeat ($urandom_range(0, 1)) send_item(oct_digit(), 1'b0);
        send_item(BACKSLASH, 1'b0);
      end else if (pick < 94) begin
        send_item(BACKSLASH, 1'b0);
        case ($urandom_range(0, 2))
          0: begin
            repeat ($urandom_range(0, 2)) send_item(oct_digit(), 1'b0);
            send_item(bad_digit(1'b0), 1'b0);
          end
          1: begin
            send_item(LETTER_X, 1'b0);
            repeat ($urandom_range(0, 1)) send_item(hex_digit(), 1'b0);
            send_item(bad_digit(1'b1), 1'b0);
          end
          default: begin
            repeat ($urandom_range(1, 2)) send_item(oct_digit(), 1'b0);
            send_item(LETTER_X, 1'b0);
          end
        endcase
      end else begin
        // string ends inside the escape
        send_item(BACKSLASH, 1'b0);
        if ($urandom_range(0, 1)) send_item(LETTER_X, 1'b0);
        repeat ($urandom_range(0, 1)) send_item(oct_digit(), 1'b0);
        break;
      end
    end
    end_string();
  endtask

  initial begin
    rst                  = 1'b1;
    calm                 = 1'b0;
    src_ch.valid         = 1'b0;
    src_ch.in_char       = '0;
    src_ch.end_of_string = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Character extremes, every escape form, repeated x, cut escape
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\\\\\\101\\777\\xfF\\xxA0\\1\\");
    end_string();
    // Bad octal digit, x after a digit, bad hex digit, dangling escape, empty string
    send_text("\\8z");
    end_string();
    send_text("\\x1x");
    end_string();
    send_text("\\xg");
    end_string();
    send_text("\\12");
    end_string();
    end_string();

    // Limit of zero stops at the first byte
    drain();
    write_limit('0);
    send_text("ab");
    end_string();
    // Limit lowered below the count in the middle of a string
    drain();
    write_limit(MAX_OUT_LEN_RESET);
    send_text("abcde");
    drain();
    write_limit(13'd3);
    send_text("f");
    end_string();

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      write_limit(pick_limit());
      repeat ($urandom_range(4, 10)) random_string();
    end
    calm = 1'b0;
    drain();

    $display("Sent %0d items (%0d random) over %0d limit settings; checked %0d results.",
             items_sent, items_sent - random_start, cfg_writes, checked);
    $display("Directed part: all escape forms, decode errors, limit 0 and lowered.");
    if (mismatches == 0 && results_owed == 0) begin
      $display("escape_sequence_decoder_core regression: pass");
    end else begin
      $display("escape_sequence_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
